### hw/rtl/tlrr_pkg.sv
// ----------------------------------------------------------------------------
// tlrr_pkg
// Types and constants shared by the three-level round-robin scheduler.
// ----------------------------------------------------------------------------
package tlrr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_W        = 8;
    localparam int NUM_Q       = 3;

    localparam int TASK_ID_W   = 8;
    localparam int TIME_W      = 16;
    localparam int QUANTUM_W   = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = ID_W + TIME_W;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd2;

    // queue indexes
    localparam logic [1:0] Q_LOW  = 2'd0;
    localparam logic [1:0] Q_MID  = 2'd1;
    localparam logic [1:0] Q_HIGH = 2'd2;

    // priority request codes
    localparam logic [1:0] PRIO_LOW = 2'd1;
    localparam logic [1:0] PRIO_MID = 2'd2;

    // item kinds
    localparam logic KIND_ADD     = 1'b0;
    localparam logic KIND_PROCESS = 1'b1;

    typedef enum logic [2:0] {
        EV_ADDED    = 3'd0,
        EV_FINISHED = 3'd1,
        EV_REQUEUED = 3'd2,
        EV_EMPTY    = 3'd3,
        EV_DROPPED  = 3'd4
    } event_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic                 kind;
        logic [TASK_ID_W-1:0] task_id;
        logic [TIME_W-1:0]    exec_time;
        logic [1:0]           priority_req;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           event_res;
        logic [TASK_ID_W-1:0] served_id;
        logic [TIME_W-1:0]    time_left;
        logic [1:0]           level;
        logic [CNT_W-1:0]     high_count;
        logic [CNT_W-1:0]     mid_count;
        logic [CNT_W-1:0]     low_count;
    } result_t;

    typedef struct packed {
        logic   load;
        logic   exec;
        event_t event_code;
    } cmd_t;

    typedef struct packed {
        logic is_process;
        logic q_full;
        logic all_empty;
        logic will_finish;
    } status_t;

endpackage

### hw/rtl/tlrr_ctrl.sv
// ----------------------------------------------------------------------------
// tlrr_ctrl
// Command sequencer: accepts an item, then picks the event for the datapath.
// ----------------------------------------------------------------------------
module tlrr_ctrl
    import tlrr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        cmd.event_code = EV_EMPTY;
        busy           = 1'b0;
        done_next      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                cmd.load = start;
            ST_EXEC:
            begin
                busy      = 1'b1;
                cmd.exec  = 1'b1;
                done_next = 1'b1;
                if (!status.is_process)
                    cmd.event_code = status.q_full ? EV_DROPPED : EV_ADDED;
                else if (status.all_empty)
                    cmd.event_code = EV_EMPTY;
                else
                    cmd.event_code = status.will_finish ? EV_FINISHED : EV_REQUEUED;
            end
            default:
                cmd.load = 1'b0;
        endcase
    end

    assign done = done_reg;

endmodule

### hw/rtl/tlrr_datapath.sv
// ----------------------------------------------------------------------------
// tlrr_datapath
// Queue stores, head and tail pointers, fill counts, quantum register and
// the result register.
// ----------------------------------------------------------------------------
module tlrr_datapath
    import tlrr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [QUANTUM_W-1:0] cfg_wr_data,
    input  in_item_t             task_item,
    input  cmd_t                 cmd,
    output status_t              status,
    output result_t              result
);

    logic [ENTRY_W-1:0]   store_mem [NUM_Q][QUEUE_DEPTH];
    logic [ENTRY_W-1:0]   head_word_reg;
    logic [PTR_W-1:0]     head_reg [NUM_Q];
    logic [PTR_W-1:0]     tail_reg [NUM_Q];
    logic [CNT_W-1:0]     occ_reg [NUM_Q];
    logic [PTR_W-1:0]     head_next [NUM_Q];
    logic [PTR_W-1:0]     tail_next [NUM_Q];
    logic [CNT_W-1:0]     occ_next [NUM_Q];
    logic [QUANTUM_W-1:0] quantum_reg;
    in_item_t             item_reg;
    result_t              result_reg;
    result_t              result_next;

    logic [1:0]           q_sel;
    logic [1:0]           proc_q;
    logic [ID_W-1:0]      head_id;
    logic [TIME_W-1:0]    head_time;
    logic [TIME_W-1:0]    quantum_ext;
    logic [TIME_W-1:0]    time_reduced;
    logic                 mem_we;
    logic [ENTRY_W-1:0]   mem_wdata;
    logic [ID_W-1:0]      item_id;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // highest non-empty queue, the one a process item would serve
    always_comb
    begin
        if (occ_reg[Q_HIGH] != '0)
            proc_q = Q_HIGH;
        else if (occ_reg[Q_MID] != '0)
            proc_q = Q_MID;
        else
            proc_q = Q_LOW;
    end

    // queue choice: priority for an add, highest non-empty queue for a process
    always_comb
    begin
        if (item_reg.kind == KIND_ADD)
        begin
            case (item_reg.priority_req)
                PRIO_LOW: q_sel = Q_LOW;
                PRIO_MID: q_sel = Q_MID;
                default:  q_sel = Q_HIGH;
            endcase
        end
        else
            q_sel = proc_q;
    end

    assign item_id      = item_reg.task_id[ID_W-1:0];
    assign head_id      = head_word_reg[ENTRY_W-1:TIME_W];
    assign head_time    = head_word_reg[TIME_W-1:0];
    assign quantum_ext  = TIME_W'(quantum_reg);
    assign time_reduced = head_time - quantum_ext;

    assign status.is_process  = (item_reg.kind == KIND_PROCESS);
    assign status.q_full      = (occ_reg[q_sel] == CNT_W'(QUEUE_DEPTH));
    assign status.all_empty   = (occ_reg[Q_HIGH] == '0) && (occ_reg[Q_MID] == '0)
                                && (occ_reg[Q_LOW] == '0);
    assign status.will_finish = (head_time <= quantum_ext);

    always_comb
    begin
        for (int i = 0; i < NUM_Q; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            occ_next[i]  = occ_reg[i];
        end
        mem_we    = 1'b0;
        mem_wdata = {item_id, item_reg.exec_time};
        result_next.event_res  = cmd.event_code;
        result_next.served_id  = '0;
        result_next.time_left  = '0;
        result_next.level      = q_sel + 2'd1;
        case (cmd.event_code)
            EV_ADDED:
            begin
                mem_we            = cmd.exec;
                tail_next[q_sel]  = ptr_inc(tail_reg[q_sel]);
                occ_next[q_sel]   = occ_reg[q_sel] + 1'b1;
                result_next.served_id = TASK_ID_W'(item_id);
                result_next.time_left = item_reg.exec_time;
            end
            EV_DROPPED:
            begin
                result_next.served_id = TASK_ID_W'(item_id);
                result_next.time_left = item_reg.exec_time;
            end
            EV_FINISHED:
            begin
                head_next[q_sel] = ptr_inc(head_reg[q_sel]);
                occ_next[q_sel]  = occ_reg[q_sel] - 1'b1;
                result_next.served_id = TASK_ID_W'(head_id);
            end
            EV_REQUEUED:
            begin
                mem_we           = cmd.exec;
                mem_wdata        = {head_id, time_reduced};
                head_next[q_sel] = ptr_inc(head_reg[q_sel]);
                tail_next[q_sel] = ptr_inc(tail_reg[q_sel]);
                result_next.served_id = TASK_ID_W'(head_id);
                result_next.time_left = time_reduced;
            end
            default:
                result_next.level = 2'd0;
        endcase
        result_next.high_count = occ_next[Q_HIGH];
        result_next.mid_count  = occ_next[Q_MID];
        result_next.low_count  = occ_next[Q_LOW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_Q; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                occ_reg[i]  <= '0;
            end
            quantum_reg <= QUANTUM_RESET;
        end
        else
        begin
            if (cmd.exec)
            begin
                for (int i = 0; i < NUM_Q; i++)
                begin
                    head_reg[i] <= head_next[i];
                    tail_reg[i] <= tail_next[i];
                    occ_reg[i]  <= occ_next[i];
                end
            end
            if (cfg_wr_en)
                quantum_reg <= cfg_wr_data;
        end
    end

    // queue stores, one write at the tail, one head word read every cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[q_sel][tail_reg[q_sel]] <= mem_wdata;
        head_word_reg <= store_mem[proc_q][head_reg[proc_q]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= task_item;
        if (cmd.exec)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

### hw/rtl/three_level_round_robin_scheduler_core.sv
// ----------------------------------------------------------------------------
// three_level_round_robin_scheduler_core
// Three priority task queues served round robin, one quantum per process.
// ----------------------------------------------------------------------------
// done is registered from the execute state that follows the accepting edge and
//   is high for one cycle; the result register is written on the same edge
// a new item is taken only from idle (accept, then an execute cycle for the
//   head read-modify-write); busy is high during the execute cycle
// results cannot be held off; each is valid only while done is high
// reset: all queues empty, time quantum 2
module three_level_round_robin_scheduler_core
    import tlrr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_item_t             task_item,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_wr_en,
    input  logic [QUANTUM_W-1:0] cfg_wr_data
);

    cmd_t    cmd;
    status_t status;

    tlrr_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tlrr_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .task_item   (task_item),
        .cmd         (cmd),
        .status      (status),
        .result      (result)
    );

endmodule

### tb/three_level_round_robin_scheduler_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_level_round_robin_scheduler_core_tb
// Drives add and process commands into the scheduler and keeps its own copy of
// the three task queues. Each result is checked field by field against the
// item that the queue copy predicts. Sender gaps vary by phase, and the time
// quantum is rewritten between phases.
// ----------------------------------------------------------------------------
module three_level_round_robin_scheduler_core_tb;
    import tlrr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] remaining;
    } task_slot_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    in_item_t             task_item;
    logic                 done;
    result_t              result;
    logic                 cfg_wr_en;
    logic [QUANTUM_W-1:0] cfg_wr_data;

    // queue copies kept alongside the block
    task_slot_t           task_store [NUM_Q][QUEUE_DEPTH];
    int                   head_idx [NUM_Q];
    int                   tail_idx [NUM_Q];
    int                   fill [NUM_Q];
    logic [QUANTUM_W-1:0] quantum;

    result_t              pending_results [$];
    int                   fail_count;
    int                   send_idle_pct;
    int                   cycle_count;

    three_level_round_robin_scheduler_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .task_item   (task_item),
        .done        (done),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // one scheduling step on the queue copies, returning the result it gives
    function automatic result_t schedule_step(in_item_t it);
        result_t    r;
        logic [1:0] q;
        logic       found;
        task_slot_t s;
        r = '0;
        found = 1'b1;
        if (it.kind == KIND_ADD)
        begin
            if (it.priority_req == PRIO_LOW)
                q = Q_LOW;
            else if (it.priority_req == PRIO_MID)
                q = Q_MID;
            else
                q = Q_HIGH;
            r.served_id = it.task_id;
            r.time_left = it.exec_time;
            r.level     = q + 2'd1;
            if (fill[q] >= QUEUE_DEPTH)
                r.event_res = EV_DROPPED;
            else
            begin
                s.id = it.task_id;
                s.remaining = it.exec_time;
                task_store[q][tail_idx[q]] = s;
                tail_idx[q] = (tail_idx[q] + 1) % QUEUE_DEPTH;
                fill[q]++;
                r.event_res = EV_ADDED;
            end
        end
        else
        begin
            if (fill[Q_HIGH] > 0)
                q = Q_HIGH;
            else if (fill[Q_MID] > 0)
                q = Q_MID;
            else if (fill[Q_LOW] > 0)
                q = Q_LOW;
            else
            begin
                q = Q_LOW;
                found = 1'b0;
            end
            if (!found)
                r.event_res = EV_EMPTY;
            else
            begin
                s = task_store[q][head_idx[q]];
                head_idx[q] = (head_idx[q] + 1) % QUEUE_DEPTH;
                r.served_id = s.id;
                r.level = q + 2'd1;
                if (s.remaining <= TIME_W'(quantum))
                begin
                    fill[q]--;
                    r.event_res = EV_FINISHED;
                    r.time_left = '0;
                end
                else
                begin
                    s.remaining = s.remaining - TIME_W'(quantum);
                    task_store[q][tail_idx[q]] = s;
                    tail_idx[q] = (tail_idx[q] + 1) % QUEUE_DEPTH;
                    r.event_res = EV_REQUEUED;
                    r.time_left = s.remaining;
                end
            end
        end
        r.high_count = CNT_W'(fill[Q_HIGH]);
        r.mid_count  = CNT_W'(fill[Q_MID]);
        r.low_count  = CNT_W'(fill[Q_LOW]);
        return r;
    endfunction

    function automatic in_item_t add_cmd(logic [TASK_ID_W-1:0] id,
                                         logic [TIME_W-1:0] t, logic [1:0] prio);
        in_item_t it;
        it.kind = KIND_ADD;
        it.task_id = id;
        it.exec_time = t;
        it.priority_req = prio;
        return it;
    endfunction

    // unused fields of a process command carry random noise
    function automatic in_item_t process_cmd();
        in_item_t it;
        it.kind = KIND_PROCESS;
        it.task_id = TASK_ID_W'($urandom);
        it.exec_time = TIME_W'($urandom);
        it.priority_req = 2'($urandom);
        return it;
    endfunction

    // holds the item until it is taken, then maybe leaves a gap
    task automatic send_item(in_item_t it);
        int gap;
        start <= 1'b1;
        task_item <= it;
        do @(posedge clk); while (busy);
        pending_results.push_back(schedule_step(it));
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_quantum(logic [QUANTUM_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        quantum = value;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, result);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("event_res", 32'(want.event_res), 32'(result.event_res));
                check_field("served_id", 32'(want.served_id), 32'(result.served_id));
                check_field("time_left", 32'(want.time_left), 32'(result.time_left));
                check_field("level", 32'(want.level), 32'(result.level));
                check_field("high_count", 32'(want.high_count), 32'(result.high_count));
                check_field("mid_count", 32'(want.mid_count), 32'(result.mid_count));
                check_field("low_count", 32'(want.low_count), 32'(result.low_count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_empty_process();
        send_item(process_cmd());
    endtask

    // field extremes, both high priority codes, and the long task kept in low
    task automatic test_field_extremes();
        send_item(add_cmd(8'h00, 16'h0000, 2'd0));
        send_item(add_cmd(8'hFF, 16'hFFFF, PRIO_LOW));
        send_item(add_cmd(8'h5A, 16'd3, PRIO_MID));
        send_item(add_cmd(8'hA5, 16'd5, 2'd3));
        repeat (7) send_item(process_cmd());
        wait_idle();
    endtask

    task automatic test_quantum_edges();
        set_quantum(8'd0);
        // zero quantum: zero time finishes, anything else requeues unchanged
        send_item(add_cmd(8'h33, 16'd4, PRIO_MID));
        send_item(add_cmd(8'h3C, 16'd0, 2'd0));
        send_item(process_cmd());
        send_item(process_cmd());
        wait_idle();
        set_quantum(8'd255);
        send_item(process_cmd());
        send_item(process_cmd());
        wait_idle();
        set_quantum(8'd1);
        send_item(add_cmd(8'h77, 16'd2, 2'd3));
        send_item(process_cmd());
        send_item(process_cmd());
        wait_idle();
    endtask

    // fill each level past its depth, then serve it back down
    task automatic test_queue_overflow();
        set_quantum(8'd255);
        for (int p = 1; p <= 3; p++)
        begin
            repeat (QUEUE_DEPTH + 1)
                send_item(add_cmd(TASK_ID_W'($urandom), TIME_W'($urandom_range(1, 255)),
                                  2'(p)));
            repeat (QUEUE_DEPTH) send_item(process_cmd());
        end
        wait_idle();
    endtask

    // bursts that lean towards adding or towards serving
    task automatic test_random_traffic(int count);
        int         burst_left;
        int         add_pct;
        int         pick;
        in_item_t   it;
        burst_left = 0;
        add_pct = 50;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(4, 24);
                add_pct = $urandom_range(1) ? 75 : 30;
            end
            burst_left--;
            if ($urandom_range(99) < add_pct)
            begin
                pick = $urandom_range(99);
                it = add_cmd(TASK_ID_W'($urandom), TIME_W'($urandom_range(1, 12)),
                             2'($urandom_range(3)));
                // long tasks only go low so they cannot starve the other levels
                if (pick < 3)
                begin
                    it.exec_time = TIME_W'($urandom_range(0, 65535));
                    it.priority_req = PRIO_LOW;
                end
                else if (pick < 8)
                    it.exec_time = '0;
            end
            else
                it = process_cmd();
            send_item(it);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        task_item <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        quantum = QUANTUM_RESET;
        for (int q = 0; q < NUM_Q; q++)
        begin
            head_idx[q] = 0;
            tail_idx[q] = 0;
            fill[q] = 0;
            for (int i = 0; i < QUEUE_DEPTH; i++)
                task_store[q][i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_process();
        test_field_extremes();
        test_quantum_edges();
        test_queue_overflow();

        set_quantum(8'd2);
        send_idle_pct = 38;
        test_random_traffic(330);
        wait_idle();
        set_quantum(8'($urandom_range(1, 6)));
        send_idle_pct = 77;
        test_random_traffic(330);
        wait_idle();
        set_quantum(8'($urandom_range(0, 255)));
        send_idle_pct = 0;
        test_random_traffic(330);
        wait_idle();
        repeat (4) @(posedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
